/* design/hilbert_curve_segment_generator_defines.svh */
// Assertion macros for the Hilbert curve segment generator datapath.
`ifndef HILBERT_CURVE_SEGMENT_GENERATOR_DEFINES_SVH
`define HILBERT_CURVE_SEGMENT_GENERATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define HCSG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define HCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* design/hcsg_pkg.sv */
// Shared constants, types and codes for the Hilbert curve segment generator.
package hcsg_pkg;

  localparam int unsigned MAX_ORDER  = 10;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned LEVEL_W    = $clog2(MAX_ORDER);
  localparam int unsigned ORDER_W    = 4;
  localparam int unsigned CMP_W      = ORDER_W + 1;
  localparam int unsigned STEP_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER   = 3'd0,
    CFG_STEP    = 3'd1,
    CFG_SPAN    = 3'd2,
    CFG_START_X = 3'd3,
    CFG_START_Y = 3'd4,
    CFG_DIR     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_UP_Y   = 2'd0,
    DIR_DOWN_Y = 2'd1,
    DIR_DOWN_X = 2'd2,
    DIR_UP_X   = 2'd3
  } dir_e;

  // One recursion frame: moves done so far, and the swap/negate turn.
  typedef struct packed {
    logic [1:0] moves;
    logic [1:0] turn;
  } frame_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic push;
    logic move;
    logic pop;
    logic finish;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic deeper;
    logic top_done;
    logic at_root;
    logic out_free;
  } dp_status_t;

endpackage

/* design/hcsg_ctrl.sv */
// Controller state machine sequencing the descent, move and unwind of one segment.
module hcsg_ctrl
  import hcsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       restart_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_DESC_PRE  = 6'b000010,
    ST_MOVE      = 6'b000100,
    ST_DESC_POST = 6'b001000,
    ST_UNWIND    = 6'b010000,
    ST_EMIT      = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (restart_i || !status_i.active) begin
            cmd_o.init = 1'b1;
            state_d    = ST_DESC_PRE;
          end else begin
            state_d = ST_MOVE;
          end
        end
      end
      ST_DESC_PRE: begin
        if (status_i.deeper) begin
          cmd_o.push = 1'b1;
        end else begin
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = status_i.deeper ? ST_DESC_POST : ST_UNWIND;
      end
      ST_DESC_POST: begin
        if (status_i.deeper) begin
          cmd_o.push = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_UNWIND: begin
        if (status_i.top_done) begin
          if (status_i.at_root) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_EMIT;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/hcsg_datapath.sv */
// Datapath: configuration registers, frame stack, pen position and output register.
`include "hilbert_curve_segment_generator_defines.svh"

module hcsg_datapath
  import hcsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [COORD_BITS-1:0] from_x_o,
  output logic [COORD_BITS-1:0] from_y_o,
  output logic [COORD_BITS-1:0] to_x_o,
  output logic [COORD_BITS-1:0] to_y_o,
  output logic                  last_o
);

  logic [ORDER_W-1:0]    cfg_order_q;
  logic [STEP_W-1:0]     cfg_step_q;
  logic [COORD_BITS-1:0] cfg_span_q, cfg_start_x_q, cfg_start_y_q;
  dir_e                  cfg_dir_q;

  frame_t                frame_q [MAX_ORDER];
  logic [LEVEL_W-1:0]    level_q, level_nx;
  logic                  active_q, last_q;
  logic [COORD_BITS-1:0] pen_x_q, pen_y_q;
  logic [COORD_BITS-1:0] res_from_x_q, res_from_y_q;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_from_x_q, out_from_y_q, out_to_x_q, out_to_y_q;
  logic                  out_last_q;

  logic [ORDER_W-1:0]    eff_order;
  frame_t                cur, moved_frame, child_frame;
  logic [1:0]            p_clip, p_new;
  logic                  swap, neg;
  logic [COORD_BITS-1:0] step, half, r1, r2, va, vb, dx, dy;
  logic [COORD_BITS-1:0] init_x, init_y;

  // Out-of-range orders are clamped to the supported range.
  always_comb begin
    if (cfg_order_q == '0) begin
      eff_order = ORDER_W'(1);
    end else if (cfg_order_q > ORDER_W'(MAX_ORDER)) begin
      eff_order = ORDER_W'(MAX_ORDER);
    end else begin
      eff_order = cfg_order_q;
    end
  end

  assign cur      = frame_q[level_q];
  assign level_nx = level_q + LEVEL_W'(1);

  assign status_o.active   = active_q;
  assign status_o.deeper   = (CMP_W'(level_q) + CMP_W'(1)) < CMP_W'(eff_order);
  assign status_o.top_done = (cur.moves == 2'd3);
  assign status_o.at_root  = (level_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // The root move is turned by the frame's swap/negate, then by the move number.
  always_comb begin
    step = COORD_BITS'(cfg_step_q);
    half = COORD_BITS'(cfg_step_q >> 1);
    r1   = '0;
    r2   = '0;
    case (cfg_dir_q)
      DIR_UP_Y:   r2 = step;
      DIR_DOWN_Y: r2 = '0 - step;
      DIR_DOWN_X: r1 = '0 - step;
      DIR_UP_X:   r1 = step;
      default:    r1 = step;
    endcase
    p_clip = (cur.moves == 2'd3) ? 2'd2 : cur.moves;
    swap   = cur.turn[0] ^ (p_clip == 2'd1);
    neg    = cur.turn[1] ^ (p_clip == 2'd2);
    va     = swap ? r2 : r1;
    vb     = swap ? r1 : r2;
    dx     = neg ? ('0 - va) : va;
    dy     = neg ? ('0 - vb) : vb;
    p_new  = p_clip + 2'd1;
    moved_frame.moves = p_new;
    moved_frame.turn  = cur.turn;
    child_frame.moves = 2'd0;
    if (cmd_i.push) begin
      child_frame.turn = cur.turn ^ 2'b01;
    end else begin
      child_frame.turn = cur.turn ^ ((p_new == 2'd3) ? 2'b11 : 2'b00);
    end
    if (cfg_dir_q == DIR_UP_Y || cfg_dir_q == DIR_UP_X) begin
      init_x = cfg_start_x_q + half;
      init_y = cfg_start_y_q + half;
    end else begin
      init_x = cfg_start_x_q + cfg_span_q - half;
      init_y = cfg_start_y_q + cfg_span_q - half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_order_q   <= ORDER_W'(1);
      cfg_step_q    <= STEP_W'(1);
      cfg_span_q    <= '0;
      cfg_start_x_q <= '0;
      cfg_start_y_q <= '0;
      cfg_dir_q     <= DIR_UP_Y;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ORDER:   cfg_order_q   <= cfg_data_i[ORDER_W-1:0];
        CFG_STEP:    cfg_step_q    <= cfg_data_i[STEP_W-1:0];
        CFG_SPAN:    cfg_span_q    <= COORD_BITS'(cfg_data_i);
        CFG_START_X: cfg_start_x_q <= COORD_BITS'(cfg_data_i);
        CFG_START_Y: cfg_start_y_q <= COORD_BITS'(cfg_data_i);
        CFG_DIR:     cfg_dir_q     <= dir_e'(cfg_data_i[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      active_q    <= 1'b0;
      last_q      <= 1'b0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        level_q  <= '0;
        active_q <= 1'b1;
        last_q   <= 1'b0;
        pen_x_q  <= init_x;
        pen_y_q  <= init_y;
      end
      if (cmd_i.push || (cmd_i.move && status_o.deeper)) begin
        level_q <= level_nx;
      end
      if (cmd_i.move) begin
        last_q  <= 1'b0;
        pen_x_q <= pen_x_q + dx;
        pen_y_q <= pen_y_q + dy;
      end
      if (cmd_i.pop) begin
        level_q <= level_q - LEVEL_W'(1);
      end
      if (cmd_i.finish) begin
        active_q <= 1'b0;
        last_q   <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      frame_q[0] <= '0;
    end
    if (cmd_i.move) begin
      frame_q[level_q] <= moved_frame;
      res_from_x_q     <= pen_x_q;
      res_from_y_q     <= pen_y_q;
    end
    if (cmd_i.push || (cmd_i.move && status_o.deeper)) begin
      frame_q[level_nx] <= child_frame;
    end
    if (cmd_i.emit) begin
      out_from_x_q <= res_from_x_q;
      out_from_y_q <= res_from_y_q;
      out_to_x_q   <= pen_x_q;
      out_to_y_q   <= pen_y_q;
      out_last_q   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign from_x_o    = out_from_x_q;
  assign from_y_o    = out_from_y_q;
  assign to_x_o      = out_to_x_q;
  assign to_y_o      = out_to_y_q;
  assign last_o      = out_last_q;

  `HCSG_ASSERT(a_level_bound, CMP_W'(level_q) < CMP_W'(MAX_ORDER), "frame level beyond stack depth")
  `HCSG_ASSERT(a_cmd_single, $onehot0(cmd_i), "more than one datapath command at once")
  `HCSG_ASSERT(a_finish_root, !cmd_i.finish || (level_q == '0), "walk finished away from root")
  `HCSG_ASSERT_NEXT(a_finish_state, cmd_i.finish, !active_q && last_q, "finish did not end walk")

endmodule

/* design/hilbert_curve_segment_generator.sv */
// A restart descends one frame per cycle; every word then makes one move and descends or
// unwinds one frame per cycle. The next word is accepted the cycle after the result
// enters the output register, which holds it while the consumer stalls.
// Reset (rst_ni, asynchronous, active low) clears the walk, the output valid flag and
// the configuration registers to order 1, step 1 and zero for the rest.
module hilbert_curve_segment_generator
  import hcsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel: one word asks for the next segment, or a fresh walk.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  // Output channel: one word per segment.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] from_x_o,
  output logic [COORD_BITS-1:0] from_y_o,
  output logic [COORD_BITS-1:0] to_x_o,
  output logic [COORD_BITS-1:0] to_y_o,
  output logic                  last_o
);

  // The controller walks the frame stack one level per cycle. A word that
  // starts a walk first loads the pen from the corner and descends to the
  // deepest level; every word then makes one step-sized move, after which the walk
  // either descends again into the next child frame or unwinds past frames
  // that have done all three moves. Unwinding out of the root frame marks
  // the last segment and ends the walk, so the following word starts anew.
  dp_cmd_t    cmd;
  dp_status_t status;

  hcsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the frame stack and the output stage;
  // the output register lets the next word in while a result still waits.
  hcsg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .from_x_o    (from_x_o),
    .from_y_o    (from_y_o),
    .to_x_o      (to_x_o),
    .to_y_o      (to_y_o),
    .last_o      (last_o)
  );

endmodule
